### sv/program_stream_demux_assert.svh
// Assertion macros for the program stream demultiplexer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PROGRAM_STREAM_DEMUX_ASSERT_SVH
`define PROGRAM_STREAM_DEMUX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/psd_pkg.sv
package psd_pkg;

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_LEN        = 4'd1,
    PH_PACK_FIX   = 4'd2,
    PH_PACK_STUFF = 4'd3,
    PH_SKIP       = 4'd4,
    PH_PES_FLAGS  = 4'd5,
    PH_PES_HLEN   = 4'd6,
    PH_PES_HSKIP  = 4'd7,
    PH_SUBID      = 4'd8,
    PH_PAYLOAD    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VIDEO   = 2'd0,
    KIND_AUDIO   = 2'd1,
    KIND_PRIVATE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD   = 3'd0,
    EV_END       = 3'd1,
    EV_UNKNOWN   = 3'd2,
    EV_SUBSTREAM = 3'd3,
    EV_BADLEN    = 3'd4
  } event_t;

  typedef struct packed {
    logic       valid;
    event_t     event_code;
    logic [7:0] payload_byte;
    logic       stream_tag;
    logic       packet_last;
  } result_t;

  localparam logic [31:0] SC_PROGRAM_END = 32'h0000_01B9;
  localparam logic [31:0] SC_PACK        = 32'h0000_01BA;
  localparam logic [31:0] SC_SYSTEM      = 32'h0000_01BB;
  localparam logic [31:0] SC_PADDING     = 32'h0000_01BE;
  localparam logic [31:0] SC_VIDEO_FIRST = 32'h0000_01E0;
  localparam logic [31:0] SC_VIDEO_LAST  = 32'h0000_01EF;
  localparam logic [31:0] SC_PRIVATE     = 32'h0000_01BD;
  localparam logic [31:0] AUDIO_ID_RESET = 32'hFFA0_0000;

  localparam logic [15:0] START_CODE_BYTES = 16'd4;
  localparam logic [15:0] LENGTH_BYTES     = 16'd2;
  localparam logic [15:0] SUBID_BYTES      = 16'd4;
  localparam logic [15:0] PACK_FIX_BYTES   = 16'd7;
  localparam logic [15:0] PES_FLAG_BYTES   = 16'd2;
  localparam logic [15:0] PES_MIN_EXTRA    = 16'd3;
  localparam logic [16:0] VIDEO_NEED_EXTRA = 17'd3;
  localparam logic [16:0] PRIV_NEED_EXTRA  = 17'd7;

endpackage

### sv/psd_in_stage.sv
module psd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !advance);
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_stream_byte;
    end
  end

endmodule

### sv/psd_parser.sv
module psd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       stream_byte,
  input  logic [31:0]      audio_id,
  output psd_pkg::result_t res
);

  psd_pkg::phase_t phase_r;
  psd_pkg::phase_t phase_nxt;
  psd_pkg::kind_t  kind_r;
  psd_pkg::kind_t  kind_nxt;
  logic [15:0]     cnt_r;
  logic [15:0]     cnt_nxt;
  logic [31:0]     hw_r;
  logic [31:0]     hw_nxt;
  logic [15:0]     len_r;
  logic [15:0]     len_nxt;
  logic            halted_r;
  logic            halted_nxt;

  logic [15:0] cnt_inc;
  logic [15:0] cnt_dec;
  logic [31:0] hw_shift;
  logic [15:0] len_shift;
  logic [15:0] len_dec;
  logic [15:0] len_hdr;
  logic [15:0] len_sub;
  logic [16:0] hlen_need;
  logic        hlen_short;
  logic        id_known;
  logic        start_done;
  logic        len_done;
  logic        subid_done;

  assign cnt_inc    = cnt_r + 16'd1;
  assign cnt_dec    = (cnt_r == 16'd0) ? 16'd0 : cnt_r - 16'd1;
  assign hw_shift   = {hw_r[23:0], stream_byte};
  assign len_shift  = {len_r[7:0], stream_byte};
  assign len_dec    = (len_r == 16'd0) ? 16'd0 : len_r - 16'd1;
  assign len_hdr    = len_r - {8'd0, stream_byte} - psd_pkg::PES_MIN_EXTRA;
  assign len_sub    = len_r - psd_pkg::SUBID_BYTES;
  assign hlen_need  = {9'd0, stream_byte} + ((kind_r == psd_pkg::KIND_PRIVATE) ?
                      psd_pkg::PRIV_NEED_EXTRA : psd_pkg::VIDEO_NEED_EXTRA);
  assign hlen_short = {1'b0, len_r} < hlen_need;
  assign start_done = cnt_inc >= psd_pkg::START_CODE_BYTES;
  assign len_done   = cnt_inc >= psd_pkg::LENGTH_BYTES;
  assign subid_done = cnt_inc >= psd_pkg::SUBID_BYTES;
  assign id_known   = (hw_r == psd_pkg::SC_PACK) || (hw_r == psd_pkg::SC_SYSTEM) ||
                      (hw_r == psd_pkg::SC_PADDING) || (hw_r == psd_pkg::SC_PRIVATE) ||
                      ((hw_r >= psd_pkg::SC_VIDEO_FIRST) && (hw_r <= psd_pkg::SC_VIDEO_LAST));

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    cnt_nxt    = cnt_r;
    hw_nxt     = hw_r;
    len_nxt    = len_r;
    halted_nxt = halted_r;
    if (!halted_r) begin
      case (phase_r)
        psd_pkg::PH_START: begin
          hw_nxt  = hw_shift;
          cnt_nxt = cnt_inc;
          if (start_done) begin
            cnt_nxt = 16'd0;
            if (hw_shift == psd_pkg::SC_PROGRAM_END) begin
              halted_nxt = 1'b1;
            end else begin
              len_nxt   = 16'd0;
              phase_nxt = psd_pkg::PH_LEN;
            end
          end
        end
        psd_pkg::PH_LEN: begin
          len_nxt = len_shift;
          cnt_nxt = cnt_inc;
          if (len_done) begin
            cnt_nxt = 16'd0;
            if (hw_r == psd_pkg::SC_PACK) begin
              cnt_nxt   = psd_pkg::PACK_FIX_BYTES;
              phase_nxt = psd_pkg::PH_PACK_FIX;
            end else if ((hw_r == psd_pkg::SC_SYSTEM) || (hw_r == psd_pkg::SC_PADDING)) begin
              cnt_nxt   = len_shift;
              phase_nxt = (len_shift == 16'd0) ? psd_pkg::PH_START : psd_pkg::PH_SKIP;
            end else if ((hw_r >= psd_pkg::SC_VIDEO_FIRST) &&
                         (hw_r <= psd_pkg::SC_VIDEO_LAST)) begin
              kind_nxt  = psd_pkg::KIND_VIDEO;
              cnt_nxt   = psd_pkg::PES_FLAG_BYTES;
              phase_nxt = psd_pkg::PH_PES_FLAGS;
            end else if (hw_r == psd_pkg::SC_PRIVATE) begin
              kind_nxt  = psd_pkg::KIND_PRIVATE;
              cnt_nxt   = psd_pkg::PES_FLAG_BYTES;
              phase_nxt = psd_pkg::PH_PES_FLAGS;
            end else begin
              halted_nxt = 1'b1;
            end
          end
        end
        psd_pkg::PH_PACK_FIX: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == 16'd0) begin
            phase_nxt = psd_pkg::PH_PACK_STUFF;
          end
        end
        psd_pkg::PH_PACK_STUFF: begin
          cnt_nxt   = {13'd0, stream_byte[2:0]};
          phase_nxt = (stream_byte[2:0] == 3'd0) ? psd_pkg::PH_START : psd_pkg::PH_SKIP;
        end
        psd_pkg::PH_SKIP: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == 16'd0) begin
            phase_nxt = psd_pkg::PH_START;
          end
        end
        psd_pkg::PH_PES_FLAGS: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == 16'd0) begin
            phase_nxt = psd_pkg::PH_PES_HLEN;
          end
        end
        psd_pkg::PH_PES_HLEN: begin
          if (hlen_short) begin
            halted_nxt = 1'b1;
          end else begin
            len_nxt = len_hdr;
            if (stream_byte != 8'd0) begin
              cnt_nxt   = {8'd0, stream_byte};
              phase_nxt = psd_pkg::PH_PES_HSKIP;
            end else if (kind_r == psd_pkg::KIND_PRIVATE) begin
              cnt_nxt   = 16'd0;
              hw_nxt    = 32'd0;
              phase_nxt = psd_pkg::PH_SUBID;
            end else begin
              cnt_nxt   = 16'd0;
              phase_nxt = (len_hdr == 16'd0) ? psd_pkg::PH_START : psd_pkg::PH_PAYLOAD;
            end
          end
        end
        psd_pkg::PH_PES_HSKIP: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == 16'd0) begin
            if (kind_r == psd_pkg::KIND_PRIVATE) begin
              hw_nxt    = 32'd0;
              phase_nxt = psd_pkg::PH_SUBID;
            end else begin
              phase_nxt = (len_r == 16'd0) ? psd_pkg::PH_START : psd_pkg::PH_PAYLOAD;
            end
          end
        end
        psd_pkg::PH_SUBID: begin
          hw_nxt  = hw_shift;
          cnt_nxt = cnt_inc;
          if (subid_done) begin
            if (hw_shift != audio_id) begin
              halted_nxt = 1'b1;
            end else begin
              kind_nxt  = psd_pkg::KIND_AUDIO;
              len_nxt   = len_sub;
              cnt_nxt   = 16'd0;
              phase_nxt = (len_sub == 16'd0) ? psd_pkg::PH_START : psd_pkg::PH_PAYLOAD;
            end
          end
        end
        psd_pkg::PH_PAYLOAD: begin
          len_nxt = len_dec;
          if (len_dec == 16'd0) begin
            phase_nxt = psd_pkg::PH_START;
          end
        end
        default: begin
          phase_nxt = psd_pkg::PH_START;
          cnt_nxt   = 16'd0;
          hw_nxt    = 32'd0;
        end
      endcase
    end
  end

  always_comb begin
    res = '{valid: 1'b0, event_code: psd_pkg::EV_PAYLOAD, payload_byte: 8'd0,
            stream_tag: 1'b0, packet_last: 1'b0};
    if (!halted_r) begin
      case (phase_r)
        psd_pkg::PH_START: begin
          if (start_done && (hw_shift == psd_pkg::SC_PROGRAM_END)) begin
            res.valid      = 1'b1;
            res.event_code = psd_pkg::EV_END;
          end
        end
        psd_pkg::PH_LEN: begin
          if (len_done && !id_known) begin
            res.valid      = 1'b1;
            res.event_code = psd_pkg::EV_UNKNOWN;
          end
        end
        psd_pkg::PH_PES_HLEN: begin
          if (hlen_short) begin
            res.valid      = 1'b1;
            res.event_code = psd_pkg::EV_BADLEN;
          end
        end
        psd_pkg::PH_SUBID: begin
          if (subid_done && (hw_shift != audio_id)) begin
            res.valid      = 1'b1;
            res.event_code = psd_pkg::EV_SUBSTREAM;
          end
        end
        psd_pkg::PH_PAYLOAD: begin
          res.valid        = 1'b1;
          res.payload_byte = stream_byte;
          res.stream_tag   = (kind_r == psd_pkg::KIND_AUDIO);
          res.packet_last  = (len_dec == 16'd0);
        end
        default: begin
          res.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= psd_pkg::PH_START;
      kind_r   <= psd_pkg::KIND_VIDEO;
      cnt_r    <= 16'd0;
      hw_r     <= 32'd0;
      len_r    <= 16'd0;
      halted_r <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      cnt_r    <= cnt_nxt;
      hw_r     <= hw_nxt;
      len_r    <= len_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

### sv/psd_out_stage.sv
module psd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  psd_pkg::result_t res,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_event_code,
  output logic [7:0]       out_payload_byte,
  output logic             out_stream_tag,
  output logic             out_packet_last
);

  logic             valid_r;
  logic             valid_nxt;
  psd_pkg::result_t res_r;

  assign valid_nxt        = load || (valid_r && !out_ready);
  assign busy             = valid_r && !out_ready;
  assign out_valid        = valid_r;
  assign out_event_code   = res_r.event_code;
  assign out_payload_byte = res_r.payload_byte;
  assign out_stream_tag   = res_r.stream_tag;
  assign out_packet_last  = res_r.packet_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### sv/program_stream_demux.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_stream_byte
// out      output     out_valid/out_ready  out_event_code, out_payload_byte,
//                                          out_stream_tag, out_packet_last
// cfg      input      cfg_valid/cfg_ready  cfg_audio_substream_id
//
// One byte is parsed per cycle from the input register, except while a byte with a result waits on a stalled output.
// A result appears at the output register the cycle after the byte is parsed.
// A byte that gives no result is parsed even while the output register is stalled.
// Reset is synchronous and active low; it returns the parser to awaiting a start code.
module program_stream_demux (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_code,
  output logic [7:0]  out_payload_byte,
  output logic        out_stream_tag,
  output logic        out_packet_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_audio_substream_id
);

  logic [31:0]      audio_id_r;
  logic             byte_valid;
  logic [7:0]       byte_data;
  logic             advance;
  logic             out_busy;
  psd_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign advance   = byte_valid && (!out_busy || !res.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      audio_id_r <= psd_pkg::AUDIO_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      audio_id_r <= cfg_audio_substream_id;
    end
  end

  psd_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .advance        (advance),
    .byte_valid     (byte_valid),
    .byte_data      (byte_data)
  );

  psd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .stream_byte (byte_data),
    .audio_id    (audio_id_r),
    .res         (res)
  );

  psd_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (advance && res.valid),
    .res              (res),
    .busy             (out_busy),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_code   (out_event_code),
    .out_payload_byte (out_payload_byte),
    .out_stream_tag   (out_stream_tag),
    .out_packet_last  (out_packet_last)
  );

endmodule

### sv/psd_checker.sv
`include "program_stream_demux_assert.svh"

module psd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_event_code,
  input logic [7:0] out_payload_byte,
  input logic       out_stream_tag,
  input logic       out_packet_last
);

  `PSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_event_code) && $stable(out_payload_byte) &&
                   $stable(out_stream_tag) && $stable(out_packet_last),
                   "Stalled result changed.")
  `PSD_ASSERT_SAME(a_event_range, out_valid, out_event_code <= psd_pkg::EV_BADLEN,
                   "Event code out of range.")
  `PSD_ASSERT_SAME(a_event_clean, out_valid && (out_event_code != psd_pkg::EV_PAYLOAD),
                   (out_payload_byte == 8'd0) && !out_stream_tag && !out_packet_last,
                   "Event carries payload fields.")
  `PSD_ASSERT_NEXT(a_halt_final,
                   out_valid && out_ready && (out_event_code != psd_pkg::EV_PAYLOAD),
                   !out_valid, "Result after a halting event.")

endmodule

bind program_stream_demux psd_checker u_psd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_event_code   (out_event_code),
  .out_payload_byte (out_payload_byte),
  .out_stream_tag   (out_stream_tag),
  .out_packet_last  (out_packet_last)
);
